// ----- rtl/dpac_pkg.sv -----
// shared types and constants of the airspeed conversion datapath
package dpac_pkg;

  // configuration port
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgPressureScale  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPressureOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAirspeedScale  = 2'd2;

  localparam logic [31:0] PressureScaleRst  = 32'd17651662;
  localparam logic [31:0] PressureOffsetRst = 32'd2206322;
  localparam logic [15:0] AirspeedScaleRst  = 16'd6688;

  // field and datapath widths
  localparam int unsigned StatusW = 2;
  localparam int unsigned PRawW   = 14;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned ProdW   = 46;
  localparam int unsigned FracDrop = 16;
  localparam int unsigned ScaledW = ProdW - FracDrop;
  localparam int unsigned PressW  = 32;
  localparam int unsigned PPosW   = 30;
  localparam int unsigned TRawW   = 11;
  localparam int unsigned TMulW   = 22;
  localparam int unsigned TempW   = 12;
  localparam int unsigned AsW     = 16;
  localparam int unsigned RadW    = 46;
  localparam int unsigned RootW   = RadW / 2;
  localparam int unsigned RemW    = RootW + 3;
  localparam int unsigned AirW    = 22;
  localparam int unsigned SqrtSteps = RootW;

  localparam logic [StatusW-1:0] StatusGood = 2'd0;
  localparam logic [TMulW-1:0]   TempGain   = 22'd2000;
  localparam logic [TempW-1:0]   TempDiv    = 12'd2047;
  localparam logic [TempW-1:0]   TempDiv2   = 12'd4094;
  localparam logic [TempW-1:0]   TempBias   = 12'd500;
  localparam logic [ProdW-1:0]   RoundHalf  = 46'd32768;
  localparam logic [PressW-1:0]  PressMin   = 32'h8000_0000;

  typedef struct packed {
    logic [ScaleW-1:0] press_gain;
    logic [31:0]       press_bias;
    logic [AsW-1:0]    speed_gain;
  } cfg_t;

  typedef struct packed {
    logic [7:0] status_pressure_high;
    logic [7:0] pressure_low;
    logic [7:0] temp_high;
    logic [7:0] temp_low;
  } in_beat_t;

  typedef struct packed {
    logic                     valid_res;
    logic [StatusW-1:0]       sensor_status;
    logic signed [PressW-1:0] press_q8;
    logic signed [TempW-1:0]  temperature;
    logic [AirW-1:0]          airspeed;
  } out_beat_t;

  // values that ride along the square root pipeline
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PressW-1:0]  pressure;
    logic [TempW-1:0]   temp;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [RadW-1:0] rad;
  } mid_beat_t;

endpackage

// ----- rtl/dpac_stream_if.sv -----
// valid/ready stream channel carrying one beat type
interface dpac_stream_if #(parameter type beat_t = logic);
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/dpac_conv.sv -----
// front stages: pressure scaling, temperature conversion, radicand product
module dpac_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpac_pkg::cfg_t    cfg_i,
  dpac_stream_if.sink       in_i,
  dpac_stream_if.source     mid_o
);

  // stage 1: raw products
  logic                               v1_q, v1_d;
  logic [dpac_pkg::StatusW-1:0]       st1_q;
  logic [dpac_pkg::ProdW-1:0]         prod1_q, prod1_d;
  logic [dpac_pkg::TMulW-1:0]         tmul1_q, tmul1_d;
  logic [dpac_pkg::PRawW-1:0]         p_raw;
  logic [dpac_pkg::TRawW-1:0]         t_raw;

  // stage 2: pressure and temperature
  logic                               v2_q, v2_d;
  logic [dpac_pkg::StatusW-1:0]       st2_q;
  logic [dpac_pkg::PressW-1:0]        p2_q, p2_d;
  logic [dpac_pkg::TempW-1:0]         temp2_q, temp2_d;
  logic [dpac_pkg::ProdW-1:0]         rnd_sum;
  logic [dpac_pkg::ScaledW-1:0]       scaled;
  logic [dpac_pkg::PressW:0]          p_diff;
  logic [dpac_pkg::TRawW-1:0]         q0;
  logic [dpac_pkg::TempW-1:0]         r0, q_fix;

  // stage 3: radicand
  logic                               v3_q, v3_d;
  dpac_pkg::side_t                    side3_q;
  logic [dpac_pkg::RadW-1:0]          rad3_q, rad3_d;
  logic [dpac_pkg::PPosW-1:0]         p_pos;

  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || mid_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  assign v1_d = rdy1 ? in_i.valid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_comb begin
    p_raw   = {in_i.data.status_pressure_high[5:0], in_i.data.pressure_low};
    t_raw   = {in_i.data.temp_high, in_i.data.temp_low[7:5]};
    prod1_d = dpac_pkg::ProdW'(p_raw) * dpac_pkg::ProdW'(cfg_i.press_gain);
    tmul1_d = dpac_pkg::TMulW'(t_raw) * dpac_pkg::TempGain;
  end

  always_comb begin
    // round q.24 to q.8, subtract offset, clamp at the negative end
    rnd_sum = prod1_q + dpac_pkg::RoundHalf;
    scaled  = rnd_sum[dpac_pkg::ProdW-1:dpac_pkg::FracDrop];
    p_diff  = {3'b000, scaled} - {1'b0, cfg_i.press_bias};
    if (p_diff[dpac_pkg::PressW] && !p_diff[dpac_pkg::PressW-1]) begin
      p2_d = dpac_pkg::PressMin;
    end else begin
      p2_d = p_diff[dpac_pkg::PressW-1:0];
    end
    // divide by 2047 using 2048 = 1 mod 2047
    q0 = tmul1_q[dpac_pkg::TMulW-1:dpac_pkg::TRawW];
    r0 = {1'b0, tmul1_q[dpac_pkg::TRawW-1:0]} + {1'b0, q0};
    if (r0 >= dpac_pkg::TempDiv2) begin
      q_fix = {1'b0, q0} + 12'd2;
    end else if (r0 >= dpac_pkg::TempDiv) begin
      q_fix = {1'b0, q0} + 12'd1;
    end else begin
      q_fix = {1'b0, q0};
    end
    temp2_d = q_fix - dpac_pkg::TempBias;
    if (st1_q != dpac_pkg::StatusGood) begin
      p2_d    = '0;
      temp2_d = '0;
    end
  end

  always_comb begin
    if (!p2_q[dpac_pkg::PressW-1] && (p2_q != '0)) begin
      p_pos = p2_q[dpac_pkg::PPosW-1:0];
    end else begin
      p_pos = '0;
    end
    rad3_d = dpac_pkg::RadW'(p_pos) * dpac_pkg::RadW'(cfg_i.speed_gain);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      st1_q   <= in_i.data.status_pressure_high[7:6];
      prod1_q <= prod1_d;
      tmul1_q <= tmul1_d;
    end
    if (rdy2 && v1_q) begin
      st2_q   <= st1_q;
      p2_q    <= p2_d;
      temp2_q <= temp2_d;
    end
    if (rdy3 && v2_q) begin
      side3_q.status   <= st2_q;
      side3_q.pressure <= p2_q;
      side3_q.temp     <= temp2_q;
      rad3_q           <= rad3_d;
    end
  end

  assign mid_o.valid     = v3_q;
  assign mid_o.data.side = side3_q;
  assign mid_o.data.rad  = rad3_q;

endmodule

// ----- rtl/dpac_isqrt.sv -----
// pipelined integer square root, one root bit per stage, with side payload
module dpac_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpac_stream_if.sink   mid_i,
  dpac_stream_if.source out_o
);

  localparam int unsigned Steps = dpac_pkg::SqrtSteps;

  logic [Steps-1:0]             vld_q;
  logic [Steps-1:0]             rdy;
  logic [dpac_pkg::RadW-1:0]    rad_q  [Steps];
  logic [dpac_pkg::RemW-1:0]    rem_q  [Steps];
  logic [dpac_pkg::RootW-1:0]   root_q [Steps];
  dpac_pkg::side_t              side_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [dpac_pkg::RadW-1:0]  rad_s;
    logic [dpac_pkg::RemW-1:0]  rem_s;
    logic [dpac_pkg::RootW-1:0] root_s;
    dpac_pkg::side_t            side_s;
    logic                       vld_s;
    logic [dpac_pkg::RemW-1:0]  acc, trial, rem_d;
    logic [dpac_pkg::RootW-1:0] root_d;

    if (k == 0) begin : g_head
      assign rad_s  = mid_i.data.rad;
      assign rem_s  = '0;
      assign root_s = '0;
      assign side_s = mid_i.data.side;
      assign vld_s  = mid_i.valid;
    end else begin : g_body
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign side_s = side_q[k-1];
      assign vld_s  = vld_q[k-1];
    end

    if (k == Steps - 1) begin : g_tail
      assign rdy[k] = !vld_q[k] || out_o.ready;
    end else begin : g_link
      assign rdy[k] = !vld_q[k] || rdy[k+1];
    end

    always_comb begin
      // bring down the next two radicand bits, try root*4+1
      acc   = {rem_s[dpac_pkg::RemW-3:0], rad_s[dpac_pkg::RadW-1 -: 2]};
      trial = {1'b0, root_s, 2'b01};
      if (acc >= trial) begin
        rem_d  = acc - trial;
        root_d = {root_s[dpac_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = acc;
        root_d = {root_s[dpac_pkg::RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_s) begin
        rad_q[k]  <= rad_s << 2;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_s;
      end
    end
  end

  assign mid_i.ready = rdy[0];

  // result beat straight from the last stage, root clamped to the field range
  assign out_o.valid              = vld_q[Steps-1];
  assign out_o.data.valid_res     = (side_q[Steps-1].status == dpac_pkg::StatusGood);
  assign out_o.data.sensor_status = side_q[Steps-1].status;
  assign out_o.data.press_q8      = side_q[Steps-1].pressure;
  assign out_o.data.temperature   = side_q[Steps-1].temp;
  assign out_o.data.airspeed      = root_q[Steps-1][dpac_pkg::RootW-1] ? '1 :
                                    root_q[Steps-1][dpac_pkg::AirW-1:0];

endmodule

// ----- rtl/diff_pressure_airspeed_convert_core.sv -----
// top level: configuration registers and the frame-to-airspeed pipeline
//
// Converts one 4-byte differential pressure sensor frame per beat into a
// result beat: valid flag, raw status, pressure (signed Q24.8 Pa),
// temperature (0.1 degC) and airspeed (unsigned Q12.10 m/s).
// in_i and out_o are valid/ready channels; a beat moves when both are high.
// Configuration: cfg_we_i writes cfg_data_i into the register selected by
// cfg_idx_i (0 pressure scale, 1 pressure offset, 2 airspeed scale); other
// indexes are dropped. Write only while no frame is in flight.
// Three front stages (scale multiply, offset and divide-by-2047, radicand
// multiply) and 23 square root stages, one root bit each, make up the
// pipeline. It takes one frame per cycle unless out_o stalls; every stage
// keeps a valid bit and loads when it is empty or its successor moves, so
// bubbles close up. When out_o stalls, the last stage holds its beat and
// upstream stages keep filling; in_i drops ready only once the whole
// pipeline is full. Reset empties the pipeline and loads the default scale,
// offset and airspeed factor.
module diff_pressure_airspeed_convert_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpac_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [dpac_pkg::CfgDataW-1:0]    cfg_data_i,
  dpac_stream_if.sink                      in_i,
  dpac_stream_if.source                    out_o
);

  dpac_pkg::cfg_t cfg_q;

  // interface between the front stages and the square root pipeline
  dpac_stream_if #(.beat_t(dpac_pkg::mid_beat_t)) mid_ch ();

  // register writes, out-of-range index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_gain <= dpac_pkg::PressureScaleRst;
      cfg_q.press_bias <= dpac_pkg::PressureOffsetRst;
      cfg_q.speed_gain <= dpac_pkg::AirspeedScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpac_pkg::CfgPressureScale:  cfg_q.press_gain <= cfg_data_i;
        dpac_pkg::CfgPressureOffset: cfg_q.press_bias <= cfg_data_i;
        dpac_pkg::CfgAirspeedScale:  cfg_q.speed_gain <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // scaling, temperature and radicand
  dpac_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .mid_o  (mid_ch.source)
  );

  // square root and result beat
  dpac_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mid_i  (mid_ch.sink),
    .out_o  (out_o)
  );

  // a bad status must zero every value all the way down the pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.valid_res |->
      out_o.data.press_q8 == '0 && out_o.data.temperature == '0 &&
      out_o.data.airspeed == '0)
    else $error("invalid frame produced nonzero values");

  // airspeed only from a positive pressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.airspeed != '0 |->
      out_o.data.press_q8 > 0)
    else $error("airspeed without positive pressure");

  // temperature stays in its conversion range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      out_o.data.temperature >= -12'sd500 && out_o.data.temperature <= 12'sd1500)
    else $error("temperature out of range");

  // a sink that takes beats keeps the whole pipeline moving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output drains");

endmodule

// ----- tb/sv/tb_diff_pressure_airspeed_convert_core.sv -----
// self-checking bench for the sensor frame to airspeed conversion core
module tb_diff_pressure_airspeed_convert_core;
  import dpac_pkg::*;

  // register index the core does not decode; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // arithmetic constants of the conversion
  localparam int          TempSpan    = 2000;
  localparam int          TempCounts  = 2047;
  localparam int          TempOffset  = 500;
  localparam longint      PressHi     = 64'sd2147483647;
  localparam longint      PressLo     = -64'sd2147483648;
  localparam logic [63:0] AirspeedMax = 64'd4194303;
  localparam logic [63:0] HalfLsb     = 64'd32768;

  // settle time after the last result before a register write or the end
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted   = 50;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic      send_valid = 1'b0;
  in_beat_t  send_beat  = '0;
  logic      take_ready = 1'b0;

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold-off, counted down in its own process
  int unsigned hold_cycles    = 0;

  // register contents as the core should hold them
  cfg_t cfg_now;

  in_beat_t  pending_frames[$];
  out_beat_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;

  dpac_stream_if #(.beat_t(in_beat_t))  frame_if ();
  dpac_stream_if #(.beat_t(out_beat_t)) result_if ();

  assign frame_if.valid  = send_valid;
  assign frame_if.data   = send_beat;
  assign result_if.ready = take_ready;

  diff_pressure_airspeed_convert_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (frame_if),
    .out_o      (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // conversion predictor
  // ---------------------------------------------------------------------

  // integer square root, rounded down, built one root bit at a time
  function automatic logic [63:0] floor_sqrt(logic [63:0] radicand);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic out_beat_t convert_frame(in_beat_t f, cfg_t c);
    out_beat_t   r;
    logic [13:0] p_raw;
    logic [10:0] t_raw;
    logic [63:0] scaled;
    logic [63:0] speed;
    longint      press;
    int          temp;
    r = '0;
    r.sensor_status = f.status_pressure_high[7:6];
    // any status other than good zeroes every value but the status itself
    if (r.sensor_status != StatusGood) begin
      return r;
    end
    p_raw = {f.status_pressure_high[5:0], f.pressure_low};
    // Q.24 product rounded to Q.8, then the offset taken off exactly
    scaled = ({50'd0, p_raw} * {32'd0, c.press_gain} + HalfLsb) >> 16;
    press  = longint'(scaled) - longint'({32'd0, c.press_bias});
    if (press > PressHi) press = PressHi;
    if (press < PressLo) press = PressLo;
    // temperature truncates, low five bits of the last byte are padding
    t_raw = {f.temp_high, f.temp_low[7:5]};
    temp  = (int'(t_raw) * TempSpan) / TempCounts - TempOffset;
    // airspeed only from positive pressure; Q.20 radicand gives a Q.10 root
    speed = '0;
    if (press > 0) begin
      speed = floor_sqrt(64'(press) * {48'd0, c.speed_gain});
      if (speed > AirspeedMax) speed = AirspeedMax;
    end
    r.valid_res     = 1'b1;
    r.press_q8      = press[31:0];
    r.temperature   = temp[11:0];
    r.airspeed      = speed[21:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (mismatch_count < MaxPrinted) begin
      $display("mismatch at result beat %0d: %s", results_seen, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
    end
  endtask

  // ---------------------------------------------------------------------
  // frame driver: offers queued frames, records the expectation on accept
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      send_valid <= 1'b0;
    end else begin
      // beat accepted at this edge: predict with the current registers
      if (send_valid && frame_if.ready) begin
        expected_results.push_back(convert_frame(send_beat, cfg_now));
      end
      // payload stays put while a beat waits for ready
      if (!send_valid || frame_if.ready) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          send_beat  <= pending_frames.pop_front();
          send_valid <= 1'b1;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor: compares every accepted beat with the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : collect_results
    out_beat_t want;
    if (!rst_ni) begin
      take_ready <= 1'b0;
    end else begin
      if (result_if.valid && take_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no frame outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("valid_res", 64'(result_if.data.valid_res), 64'(want.valid_res));
          check_field("sensor_status", 64'(result_if.data.sensor_status),
                      64'(want.sensor_status));
          check_field("press_q8", 64'(unsigned'(result_if.data.press_q8)),
                      64'(unsigned'(want.press_q8)));
          check_field("temperature", 64'(unsigned'(result_if.data.temperature)),
                      64'(unsigned'(want.temperature)));
          check_field("airspeed", 64'(result_if.data.airspeed), 64'(want.airspeed));
        end
        results_seen++;
      end
      take_ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold-off countdown
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_frame(logic [1:0] status, logic [13:0] p_raw, logic [10:0] t_raw,
                             logic [4:0] pad);
    in_beat_t f;
    f.status_pressure_high = {status, p_raw[13:8]};
    f.pressure_low         = p_raw[7:0];
    f.temp_high            = t_raw[10:3];
    f.temp_low             = {t_raw[2:0], pad};
    pending_frames.push_back(f);
  endtask

  // mostly good frames with random content, some pressure extremes, some faults
  function automatic in_beat_t random_frame();
    in_beat_t f;
    f = in_beat_t'($urandom);
    if ($urandom_range(99) < 75) begin
      f.status_pressure_high[7:6] = StatusGood;
    end
    case ($urandom_range(9))
      0: begin
        f.status_pressure_high[5:0] = '0;
        f.pressure_low = '0;
      end
      1: begin
        f.status_pressure_high[5:0] = '1;
        f.pressure_low = '1;
      end
      default: ;
    endcase
    return f;
  endfunction

  // wait until every frame went in and every result came out
  task automatic wait_drained();
    while (pending_frames.size() != 0 || send_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
    @(posedge clk_i);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (n) pending_frames.push_back(random_frame());
    wait_drained();
  endtask

  // register write; the core is idle whenever this is called
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CfgPressureScale:  cfg_now.press_gain = data;
      CfgPressureOffset: cfg_now.press_bias = data;
      CfgAirspeedScale:  cfg_now.speed_gain = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(logic [31:0] scale, logic [31:0] offset, logic [31:0] air);
    write_reg(CfgPressureScale, scale);
    write_reg(CfgPressureOffset, offset);
    write_reg(CfgAirspeedScale, air);
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    cfg_now.press_gain = PressureScaleRst;
    cfg_now.press_bias = PressureOffsetRst;
    cfg_now.speed_gain = AirspeedScaleRst;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed frames with reset registers, no idling
    queue_frame(StatusGood, 14'd0,      11'd0,     5'd0);
    queue_frame(StatusGood, 14'h3fff,   11'h7ff,   5'h1f);
    queue_frame(StatusGood, 14'h2000,   11'h3ff,   5'h0a);
    queue_frame(StatusGood, 14'd1,      11'd1,     5'h15);
    // around the point where scaled pressure crosses the default offset
    queue_frame(StatusGood, 14'd8191,   11'd1024,  5'd0);
    queue_frame(StatusGood, 14'd8192,   11'd1023,  5'd0);
    queue_frame(StatusGood, 14'h2aaa,   11'h555,   5'h0a);
    queue_frame(StatusGood, 14'h1555,   11'h2aa,   5'h15);
    // non-good status: reserved, already fetched, fault
    queue_frame(2'd1,       14'h3fff,   11'h7ff,   5'h1f);
    queue_frame(2'd2,       14'h3fff,   11'h7ff,   5'h1f);
    queue_frame(2'd3,       14'h3fff,   11'h7ff,   5'h1f);
    queue_frame(2'd3,       14'd0,      11'd0,     5'd0);
    queue_frame(2'd2,       14'h1234,   11'h456,   5'h11);
    queue_frame(2'd1,       14'd0,      11'd0,     5'd0);
    run_random(100, 0, 0);

    // receiver holds off while the sender keeps offering: pipeline fills up
    @(posedge clk_i);
    hold_cycles <= 400;
    run_random(120, 0, 0);

    // largest scales, no offset: airspeed saturates
    load_cfg(32'hffff_ffff, 32'd0, 32'hffff_ffff);
    queue_frame(StatusGood, 14'h3fff, 11'h7ff, 5'h1f);
    queue_frame(StatusGood, 14'd1,    11'd0,   5'd0);
    run_random(150, 85, 0);

    // no scale, largest offset: pressure saturates low, zero airspeed factor
    load_cfg(32'd0, 32'hffff_ffff, 32'd0);
    // index outside the register file is ignored
    write_reg(CfgUnused, $urandom);
    queue_frame(StatusGood, 14'h3fff, 11'h7ff, 5'h1f);
    run_random(100, 0, 85);

    // assorted random settings, both sides idling
    repeat (4) begin
      load_cfg($urandom, $urandom_range(1, 0) ? $urandom : $urandom_range(4_000_000),
               $urandom);
      run_random(110, 30, 30);
    end

    // back to small offsets with mixed idling so every phase sees both
    load_cfg(PressureScaleRst, PressureOffsetRst, AirspeedScaleRst);
    run_random(60, 85, 85);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dpac_pkg.sv
rtl/dpac_stream_if.sv
rtl/dpac_conv.sv
rtl/dpac_isqrt.sv
rtl/diff_pressure_airspeed_convert_core.sv
tb/sv/tb_diff_pressure_airspeed_convert_core.sv
